[hdl/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

[hdl/ptrrs_pkg.sv]
// Shared types and constants of the process table scheduler.
// Depends on nothing; imported by the slot table and the top level.
package ptrrs_pkg;

   typedef logic [1:0] slot_state_type;
   localparam slot_state_type SLOT_DEAD    = 2'd0;
   localparam slot_state_type SLOT_READY   = 2'd1;
   localparam slot_state_type SLOT_RUNNING = 2'd2;
   localparam slot_state_type SLOT_BLOCKED = 2'd3;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_TICK  = 2'd0;
   localparam kind_type KIND_EXIT  = 2'd1;
   localparam kind_type KIND_WAIT  = 2'd2;
   localparam kind_type KIND_SPAWN = 2'd3;

   localparam int KIND_W     = 2;
   localparam int CUR_W      = 4;
   localparam int TGT_W      = 5;
   localparam int RET_W      = 5;
   localparam int RUN_W      = 4;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   localparam logic [RET_W-1:0] RET_NONE = 5'h1f;
   localparam logic [RET_W-1:0] RET_OK   = 5'h00;

endpackage

[hdl/ptrrs_table.sv]
// Slot table memory: one entry of state, parent and waited-for slot per process.
// Depends on ptrrs_pkg; entries never written read back as dead with zero links.
module ptrrs_table import ptrrs_pkg::*; #(
   parameter int NUM_SLOTS = 16,
   localparam int IdW = $clog2(NUM_SLOTS),
   localparam int EntW = 2 + 2 * IdW
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  logic [IdW-1:0]  wr_addr,
   input  logic [EntW-1:0] wr_entry,
   input  logic [IdW-1:0]  rd_addr,
   output logic [EntW-1:0] rd_entry
);

   logic [EntW-1:0]      mem [NUM_SLOTS];
   logic [EntW-1:0]      rd_data_ff;
   logic                 rd_hit_ff;
   logic [NUM_SLOTS-1:0] valid_ff;
   logic [NUM_SLOTS-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_entry = rd_hit_ff ? rd_data_ff : {{(EntW - 2){1'b0}}, SLOT_DEAD};

endmodule

[hdl/process_table_round_robin_scheduler.sv]
// Process slot table with a round-robin scheduler; uses ptrrs_pkg and ptrrs_table.
// The slot scan reads one table entry per cycle through the single read port.
// One item is in work at a time; a finished result waits in the output register.
// Reset is synchronous: all slots read as dead and the round-robin pointer is slot one.
`include "assert_macros.svh"
module process_table_round_robin_scheduler import ptrrs_pkg::*; #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // current_pid[3:0], target_pid[8:4], from_syscall[9], file_found[10]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // kind[1:0]
   input  logic [KIND_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // ret_value[4:0], switched[5], running_pid[9:6], shutdown[10]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IdW  = $clog2(NUM_SLOTS);
   localparam int EntW = 2 + 2 * IdW;
   localparam int CntW = $clog2(NUM_SLOTS + 1);
   localparam int XW   = (CntW > TGT_W) ? CntW : TGT_W;
   localparam logic [XW-1:0]   NUM_X   = XW'(NUM_SLOTS);
   localparam logic [IdW-1:0]  ID_ZERO = '0;
   localparam logic [IdW-1:0]  ID_ONE  = IdW'(1);
   localparam logic [IdW-1:0]  LAST_ID = IdW'(NUM_SLOTS - 1);
   localparam logic [CntW-1:0] CNT_ALL = CntW'(NUM_SLOTS);
   localparam logic [CntW-1:0] CNT_NZ  = CntW'(NUM_SLOTS - 1);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_LOOK  = 10'b00_0000_0010,
      ST_TGT   = 10'b00_0000_0100,
      ST_SCAN  = 10'b00_0000_1000,
      ST_WR_NX = 10'b00_0001_0000,
      ST_P_RD  = 10'b00_0010_0000,
      ST_P_WR  = 10'b00_0100_0000,
      ST_C_RD  = 10'b00_1000_0000,
      ST_C_WR  = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   logic [IdW-1:0]   cur_ff, cur_in;
   logic [IdW-1:0]   tgt_ff, tgt_in;
   logic             tgt_ok_ff, tgt_ok_in;
   logic             sys_ff, sys_in;
   logic             file_ff, file_in;
   logic [IdW-1:0]   cur_par_ff, cur_par_in;
   logic [IdW-1:0]   cur_wt_ff, cur_wt_in;
   logic             caller_run_ff, caller_run_in;
   logic [IdW-1:0]   last_ff, last_in;
   logic [IdW-1:0]   ptr_ff, ptr_in;
   logic [CntW-1:0]  iss_ff, iss_in;
   logic [CntW-1:0]  total_ff, total_in;
   logic             pend_ff, pend_in;
   logic [IdW-1:0]   pend_addr_ff, pend_addr_in;
   logic             alive_ff, alive_in;
   logic [IdW-1:0]   nx_ff, nx_in;
   logic [IdW-1:0]   nx_par_ff, nx_par_in;
   logic [IdW-1:0]   nx_wt_ff, nx_wt_in;
   logic [RET_W-1:0] res_ret_ff, res_ret_in;
   logic             res_sw_ff, res_sw_in;
   logic [RUN_W-1:0] res_run_ff, res_run_in;
   logic             res_down_ff, res_down_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RET_W-1:0] rsp_ret_ff, rsp_ret_in;
   logic             rsp_sw_ff, rsp_sw_in;
   logic [RUN_W-1:0] rsp_run_ff, rsp_run_in;
   logic             rsp_down_ff, rsp_down_in;

   logic [CUR_W-1:0] req_cur;
   logic [TGT_W-1:0] req_tgt;
   logic             issue;
   logic             last_eval;
   logic             alive_now;
   logic             wr_en;
   logic [IdW-1:0]   wr_addr;
   logic [EntW-1:0]  wr_entry;
   logic [IdW-1:0]   rd_addr;
   logic [EntW-1:0]  rd_entry;
   slot_state_type   e_st;
   logic [IdW-1:0]   e_par;
   logic [IdW-1:0]   e_wt;

   assign req_cur = req_tdata[3:0];
   assign req_tgt = req_tdata[8:4];
   assign e_st    = rd_entry[1:0];
   assign e_par   = rd_entry[IdW+1:2];
   assign e_wt    = rd_entry[EntW-1:IdW+2];

   ptrrs_table #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_entry(wr_entry),
      .rd_addr (rd_addr),
      .rd_entry(rd_entry)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      cur_in        = cur_ff;
      tgt_in        = tgt_ff;
      tgt_ok_in     = tgt_ok_ff;
      sys_in        = sys_ff;
      file_in       = file_ff;
      cur_par_in    = cur_par_ff;
      cur_wt_in     = cur_wt_ff;
      caller_run_in = caller_run_ff;
      last_in       = last_ff;
      ptr_in        = ptr_ff;
      iss_in        = iss_ff;
      total_in      = total_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      alive_in      = alive_ff;
      nx_in         = nx_ff;
      nx_par_in     = nx_par_ff;
      nx_wt_in      = nx_wt_ff;
      res_ret_in    = res_ret_ff;
      res_sw_in     = res_sw_ff;
      res_run_in    = res_run_ff;
      res_down_in   = res_down_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_ret_in    = rsp_ret_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_down_in   = rsp_down_ff;
      req_tready    = 1'b0;
      issue         = 1'b0;
      last_eval     = 1'b0;
      alive_now     = alive_ff;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_entry      = {cur_wt_ff, cur_par_ff, SLOT_DEAD};

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cur_in     = (XW'(req_cur) < NUM_X) ? IdW'(req_cur) : ID_ZERO;
            rd_addr    = cur_in;
            if (req_tvalid) begin
               kind_in     = req_tuser;
               tgt_in      = IdW'(req_tgt);
               tgt_ok_in   = (req_tgt != '0) && (XW'(req_tgt) < NUM_X);
               sys_in      = req_tdata[9];
               file_in     = req_tdata[10];
               res_ret_in  = RET_NONE;
               res_sw_in   = 1'b0;
               res_run_in  = '0;
               res_down_in = 1'b0;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cur_par_in    = e_par;
            cur_wt_in     = e_wt;
            caller_run_in = (cur_ff != ID_ZERO) && (e_st == SLOT_RUNNING);
            rd_addr       = tgt_ff;
            iss_in        = '0;
            pend_in       = 1'b0;
            alive_in      = 1'b0;
            total_in      = CNT_NZ;
            ptr_in        = ID_ONE;
            case (kind_ff)
               KIND_TICK: begin
                  if (sys_ff && (cur_ff != ID_ZERO) && (e_st == SLOT_RUNNING)) begin
                     state_in = ST_DONE;
                  end else begin
                     ptr_in   = (last_ff == LAST_ID) ? ID_ZERO : last_ff + 1'b1;
                     total_in = CNT_ALL;
                     state_in = ST_SCAN;
                  end
               end
               KIND_EXIT: begin
                  state_in = (cur_ff == ID_ZERO) ? ST_DONE : ST_SCAN;
               end
               KIND_WAIT: begin
                  state_in = tgt_ok_ff ? ST_TGT : ST_DONE;
               end
               default: begin
                  state_in = file_ff ? ST_SCAN : ST_DONE;
               end
            endcase
         end
         ST_TGT: begin
            if (e_st == SLOT_DEAD) begin
               res_ret_in = RET_OK;
               state_in   = ST_DONE;
            end else if (cur_ff == ID_ZERO) begin
               state_in = ST_DONE;
            end else begin
               wr_en    = 1'b1;
               wr_entry = {tgt_ff, cur_par_ff, SLOT_BLOCKED};
               ptr_in   = (last_ff == LAST_ID) ? ID_ZERO : last_ff + 1'b1;
               total_in = CNT_ALL;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            issue        = (iss_ff != total_ff);
            pend_in      = issue;
            pend_addr_in = ptr_ff;
            last_eval    = pend_ff && !issue;
            if (issue) begin
               iss_in = iss_ff + 1'b1;
               ptr_in = (ptr_ff == LAST_ID) ? ID_ZERO : ptr_ff + 1'b1;
            end
            if (pend_ff) begin
               case (kind_ff)
                  KIND_EXIT: begin
                     if ((e_par == cur_ff) && (e_st != SLOT_DEAD)) begin
                        wr_en    = 1'b1;
                        wr_addr  = pend_addr_ff;
                        wr_entry = {e_wt, e_par, SLOT_DEAD};
                     end
                     if (last_eval) begin
                        state_in = (cur_par_ff != ID_ZERO) ? ST_P_RD : ST_C_RD;
                     end
                  end
                  KIND_SPAWN: begin
                     if (e_st == SLOT_DEAD) begin
                        wr_en      = 1'b1;
                        wr_addr    = pend_addr_ff;
                        wr_entry   = {ID_ZERO, cur_ff, SLOT_READY};
                        res_ret_in = RET_W'(pend_addr_ff);
                        state_in   = ST_DONE;
                     end else if (last_eval) begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     if ((pend_addr_ff != ID_ZERO) && (e_st == SLOT_READY)) begin
                        nx_in     = pend_addr_ff;
                        nx_par_in = e_par;
                        nx_wt_in  = e_wt;
                        if ((kind_ff == KIND_TICK) && caller_run_ff) begin
                           wr_en    = 1'b1;
                           wr_entry = {cur_wt_ff, cur_par_ff, SLOT_READY};
                        end
                        state_in = ST_WR_NX;
                     end else begin
                        alive_now = alive_ff
                                    || ((pend_addr_ff != ID_ZERO) && (e_st != SLOT_DEAD));
                        alive_in  = alive_now;
                        if (last_eval) begin
                           res_down_in = !alive_now;
                           if (kind_ff == KIND_WAIT) begin
                              wr_en      = 1'b1;
                              wr_entry   = {ID_ZERO, cur_par_ff, SLOT_RUNNING};
                              res_ret_in = RET_OK;
                           end
                           state_in = ST_DONE;
                        end
                     end
                  end
               endcase
            end
         end
         ST_WR_NX: begin
            wr_en      = 1'b1;
            wr_addr    = nx_ff;
            wr_entry   = {nx_wt_ff, nx_par_ff, SLOT_RUNNING};
            last_in    = nx_ff;
            res_ret_in = RET_W'(nx_ff);
            res_sw_in  = 1'b1;
            res_run_in = RUN_W'(nx_ff);
            state_in   = ST_DONE;
         end
         ST_P_RD: begin
            rd_addr  = cur_par_ff;
            state_in = ST_P_WR;
         end
         ST_P_WR: begin
            if (e_wt == cur_ff) begin
               wr_en    = 1'b1;
               wr_addr  = cur_par_ff;
               wr_entry = {ID_ZERO, e_par, (e_st == SLOT_BLOCKED) ? SLOT_READY : e_st};
            end
            state_in = ST_C_RD;
         end
         ST_C_RD: begin
            rd_addr  = cur_ff;
            state_in = ST_C_WR;
         end
         ST_C_WR: begin
            wr_en       = 1'b1;
            wr_entry    = {e_wt, e_par, SLOT_DEAD};
            res_ret_in  = RET_OK;
            res_down_in = (cur_ff == ID_ONE);
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_ret_in   = res_ret_ff;
               rsp_sw_in    = res_sw_ff;
               rsp_run_in   = res_run_ff;
               rsp_down_in  = res_down_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= ID_ONE;
         rsp_valid_ff <= 1'b0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_ff       <= iss_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      cur_ff        <= cur_in;
      tgt_ff        <= tgt_in;
      tgt_ok_ff     <= tgt_ok_in;
      sys_ff        <= sys_in;
      file_ff       <= file_in;
      cur_par_ff    <= cur_par_in;
      cur_wt_ff     <= cur_wt_in;
      caller_run_ff <= caller_run_in;
      ptr_ff        <= ptr_in;
      total_ff      <= total_in;
      pend_addr_ff  <= pend_addr_in;
      alive_ff      <= alive_in;
      nx_ff         <= nx_in;
      nx_par_ff     <= nx_par_in;
      nx_wt_ff      <= nx_wt_in;
      res_ret_ff    <= res_ret_in;
      res_sw_ff     <= res_sw_in;
      res_run_ff    <= res_run_in;
      res_down_ff   <= res_down_in;
      rsp_ret_ff    <= rsp_ret_in;
      rsp_sw_ff     <= rsp_sw_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_down_ff   <= rsp_down_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RET_W - RUN_W - 2){1'b0}},
                        rsp_down_ff, rsp_run_ff, rsp_sw_ff, rsp_ret_ff};

   `ASSERT_IMPLY(a_no_kernel_write, clock, reset, wr_en, wr_addr != ID_ZERO)
   `ASSERT_ALWAYS(a_last_not_kernel, clock, reset, last_ff != ID_ZERO)
   `ASSERT_IMPLY(a_scan_bound, clock, reset, state_ff == ST_SCAN, iss_ff <= total_ff)
   `ASSERT_IMPLY(a_switch_pid, clock, reset, rsp_valid_ff && rsp_sw_ff, rsp_ret_ff[RUN_W-1:0] == rsp_run_ff)

endmodule
